// ----- hdl/atr_pkg.sv -----
// atr_pkg: widths, types and constants shared by the average true range block
// no dependencies; imported by atr_trange, atr_divider and average_true_range
`default_nettype none

package atr_pkg;

    localparam int PRICE_WIDTH  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_PERIOD   = 4096;
    localparam int PERIOD_WIDTH = 13;
    localparam int SUM_WIDTH    = 44;
    localparam int AVG_WIDTH    = PRICE_WIDTH + FRAC_BITS;
    localparam int DIV_WIDTH    = SUM_WIDTH + FRAC_BITS;
    localparam int DIV_COUNT_WIDTH = $clog2(DIV_WIDTH + 1);

    localparam int ADDR_WIDTH = 3;
    localparam int DATA_WIDTH = 32;

    typedef logic [PRICE_WIDTH-1:0]  price_t;
    typedef logic [AVG_WIDTH-1:0]    avg_t;
    typedef logic [PERIOD_WIDTH-1:0] period_t;
    typedef logic [SUM_WIDTH-1:0]    sum_t;
    typedef logic [DIV_WIDTH-1:0]    div_t;
    typedef logic [ADDR_WIDTH-1:0]   addr_t;
    typedef logic [DATA_WIDTH-1:0]   data_t;
    typedef logic [ADDR_WIDTH-3:0]   reg_index_t;

    localparam reg_index_t REG_PERIOD = reg_index_t'(0);

    localparam period_t PERIOD_RESET = period_t'(14);
    localparam period_t PERIOD_MAX   = period_t'(MAX_PERIOD);
    localparam period_t PERIOD_ONE   = period_t'(1);

endpackage

`default_nettype wire

// ----- hdl/atr_trange.sv -----
// atr_trange: two-stage true range of one bar against the previous close
// depends on atr_pkg
`default_nettype none

module atr_trange (
    input  wire logic            clk,
    input  wire logic            load,
    input  wire atr_pkg::price_t high,
    input  wire atr_pkg::price_t low,
    input  wire atr_pkg::price_t prior_close,
    input  wire logic            use_prior,
    output atr_pkg::price_t      true_range
);
    import atr_pkg::*;

    logic [PRICE_WIDTH:0] hl_reg;
    logic [PRICE_WIDTH:0] hp_reg;
    logic [PRICE_WIDTH:0] ph_reg;
    logic [PRICE_WIDTH:0] lp_reg;
    logic [PRICE_WIDTH:0] pl_reg;
    logic                 prior_reg;
    price_t               tr_reg;
    price_t               tr_next;

    price_t hl_term;
    price_t high_term;
    price_t low_term;
    price_t max_first;
    price_t max_second;

    // stage one: all differences with their borrow bit
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hl_reg    <= {1'b0, high} - {1'b0, low};
            hp_reg    <= {1'b0, high} - {1'b0, prior_close};
            ph_reg    <= {1'b0, prior_close} - {1'b0, high};
            lp_reg    <= {1'b0, low} - {1'b0, prior_close};
            pl_reg    <= {1'b0, prior_close} - {1'b0, low};
            prior_reg <= use_prior;
        end
    end

    // stage two: absolute values and the largest term
    always_comb
    begin
        hl_term    = hl_reg[PRICE_WIDTH] ? '0 : hl_reg[PRICE_WIDTH-1:0];
        high_term  = hp_reg[PRICE_WIDTH] ? ph_reg[PRICE_WIDTH-1:0] : hp_reg[PRICE_WIDTH-1:0];
        low_term   = lp_reg[PRICE_WIDTH] ? pl_reg[PRICE_WIDTH-1:0] : lp_reg[PRICE_WIDTH-1:0];
        max_first  = (high_term > hl_term) ? high_term : hl_term;
        max_second = (low_term > max_first) ? low_term : max_first;
        tr_next    = prior_reg ? max_second : hl_term;
    end

    always_ff @(posedge clk)
    begin
        tr_reg <= tr_next;
    end

    assign true_range = tr_reg;

endmodule

`default_nettype wire

// ----- hdl/atr_divider.sv -----
// atr_divider: restoring divider, one quotient bit per cycle, narrow remainder
// depends on atr_pkg
`default_nettype none

module atr_divider (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire atr_pkg::div_t    dividend,
    input  wire atr_pkg::period_t divisor,
    output logic                  done,
    output atr_pkg::div_t         quotient
);
    import atr_pkg::*;

    div_t                       shift_reg;
    period_t                    rem_reg;
    period_t                    divisor_reg;
    logic [DIV_COUNT_WIDTH-1:0] count_reg;
    logic                       done_reg;

    logic [PERIOD_WIDTH:0] trial;
    logic [PERIOD_WIDTH:0] trial_diff;
    logic                  fits;
    period_t               rem_next;

    always_comb
    begin
        trial      = {rem_reg, shift_reg[DIV_WIDTH-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        fits       = (trial >= {1'b0, divisor_reg});
        rem_next   = fits ? trial_diff[PERIOD_WIDTH-1:0] : trial[PERIOD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            count_reg <= DIV_COUNT_WIDTH'(DIV_WIDTH);
            done_reg  <= 1'b0;
        end
        else if (count_reg != '0)
        begin
            count_reg <= count_reg - 1'b1;
            done_reg  <= (count_reg == DIV_COUNT_WIDTH'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg   <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (count_reg != '0)
        begin
            shift_reg <= {shift_reg[DIV_WIDTH-2:0], fits};
            rem_reg   <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

`default_nettype wire

// ----- hdl/average_true_range.sv -----
// average_true_range: one bar at a time; a bar that seeds or smooths the average
// passes through the divider, a bar still filling the window skips it.
// the next bar is accepted once the result sits in the output register; the
// 60-step bit-serial divider sets the rate. reset clears the series, sets the
// period to 14 and empties the output register. depends on atr_pkg, atr_trange, atr_divider
`default_nettype none

module average_true_range (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire atr_pkg::addr_t  paddr,
    input  wire atr_pkg::data_t  pwdata,
    output atr_pkg::data_t       prdata,
    output logic                 pready,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire atr_pkg::price_t bar_high,
    input  wire atr_pkg::price_t bar_low,
    input  wire atr_pkg::price_t bar_close,
    input  wire logic            series_start,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output atr_pkg::avg_t        range_average,
    output logic                 average_valid
);
    import atr_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TRANGE = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_DIVIDE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_SEED = 2'd1;
    localparam logic [1:0] MODE_UP   = 2'd2;
    localparam logic [1:0] MODE_DOWN = 2'd3;

    logic [2:0] state_reg;
    logic [1:0] mode_reg;
    period_t    period_reg;
    price_t     prior_close_reg;
    logic       have_prior_reg;
    sum_t       seed_sum_reg;
    period_t    bars_seen_reg;
    avg_t       avg_reg;
    logic       out_valid_reg;
    avg_t       range_average_reg;
    logic       average_valid_reg;

    logic       in_accept;
    logic       cfg_write;
    logic       out_free;
    period_t    window;
    price_t     true_range;
    logic       div_start;
    logic       div_done;
    div_t       quotient;
    avg_t       quotient_avg;

    logic       seeding;
    period_t    bars_inc;
    sum_t       sum_next;
    avg_t       scaled_tr;
    logic [AVG_WIDTH:0] diff_up;
    logic [AVG_WIDTH:0] diff_down;
    logic [1:0] mode_next;
    div_t       dividend_next;
    avg_t       result_avg;
    logic       result_valid;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & (paddr[ADDR_WIDTH-1:2] == REG_PERIOD);
    assign prdata    = (paddr[ADDR_WIDTH-1:2] == REG_PERIOD)
                       ? DATA_WIDTH'(period_reg) : '0;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid & ~in_stall;
    assign out_free  = ~out_valid_reg | ~out_stall;

    assign out_valid     = out_valid_reg;
    assign range_average = range_average_reg;
    assign average_valid = average_valid_reg;

    // zero acts as one, anything above the maximum acts as the maximum
    always_comb
    begin
        if (period_reg == '0)
            window = PERIOD_ONE;
        else if (period_reg > PERIOD_MAX)
            window = PERIOD_MAX;
        else
            window = period_reg;
    end

    atr_trange u_trange (
        .clk         (clk),
        .load        (in_accept),
        .high        (bar_high),
        .low         (bar_low),
        .prior_close (prior_close_reg),
        .use_prior   (have_prior_reg & ~series_start),
        .true_range  (true_range)
    );

    // seeding as sum / p, smoothing as avg + (tr - avg) / p, rounded toward minus infinity
    always_comb
    begin
        seeding   = (bars_seen_reg < window);
        bars_inc  = bars_seen_reg + 1'b1;
        sum_next  = seed_sum_reg + SUM_WIDTH'(true_range);
        scaled_tr = {true_range, FRAC_BITS'(0)};
        diff_up   = {1'b0, scaled_tr} - {1'b0, avg_reg};
        diff_down = {1'b0, avg_reg} - {1'b0, scaled_tr}
                    + (AVG_WIDTH + 1)'(window - PERIOD_ONE);

        if (seeding)
            mode_next = (bars_inc == window) ? MODE_SEED : MODE_NONE;
        else if (diff_up[AVG_WIDTH])
            mode_next = MODE_DOWN;
        else
            mode_next = MODE_UP;

        unique case (mode_next)
            MODE_SEED: dividend_next = {sum_next, FRAC_BITS'(0)};
            MODE_UP:   dividend_next = DIV_WIDTH'(diff_up[AVG_WIDTH-1:0]);
            MODE_DOWN: dividend_next = DIV_WIDTH'(diff_down);
            default:   dividend_next = '0;
        endcase

        div_start = (state_reg == ST_PREP) && (mode_next != MODE_NONE);
    end

    atr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_next),
        .divisor  (window),
        .done     (div_done),
        .quotient (quotient)
    );

    assign quotient_avg = quotient[AVG_WIDTH-1:0];

    always_comb
    begin
        unique case (mode_reg)
            MODE_SEED: result_avg = quotient_avg;
            MODE_UP:   result_avg = avg_reg + quotient_avg;
            MODE_DOWN: result_avg = avg_reg - quotient_avg;
            default:   result_avg = '0;
        endcase
        result_valid = (mode_reg != MODE_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            mode_reg          <= MODE_NONE;
            period_reg        <= PERIOD_RESET;
            prior_close_reg   <= '0;
            have_prior_reg    <= 1'b0;
            seed_sum_reg      <= '0;
            bars_seen_reg     <= '0;
            avg_reg           <= '0;
            out_valid_reg     <= 1'b0;
            range_average_reg <= '0;
            average_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        prior_close_reg <= bar_close;
                        have_prior_reg  <= 1'b1;
                        if (series_start)
                        begin
                            seed_sum_reg  <= '0;
                            bars_seen_reg <= '0;
                            avg_reg       <= '0;
                        end
                        state_reg <= ST_TRANGE;
                    end
                end
                ST_TRANGE:
                begin
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    mode_reg <= mode_next;
                    if (seeding)
                    begin
                        seed_sum_reg  <= sum_next;
                        bars_seen_reg <= bars_inc;
                    end
                    state_reg <= div_start ? ST_DIVIDE : ST_FINISH;
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        if (result_valid)
                            avg_reg <= result_avg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // output register, refilled in the cycle it is emptied
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg     <= 1'b1;
                range_average_reg <= result_valid ? result_avg : '0;
                average_valid_reg <= result_valid;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // a new period restarts the series
            if (cfg_write)
            begin
                period_reg      <= pwdata[PERIOD_WIDTH-1:0];
                prior_close_reg <= '0;
                have_prior_reg  <= 1'b0;
                seed_sum_reg    <= '0;
                bars_seen_reg   <= '0;
                avg_reg         <= '0;
            end
        end
    end

endmodule

`default_nettype wire
